// ===== rtl/sitda_pkg.sv =====
// shared types, character codes and the double-dabble step for the decimal text unit
package sitda_pkg;

  localparam int unsigned DIGITS = 10;
  localparam int unsigned BIN_W = 32;
  localparam int unsigned BCD_W = 4 * DIGITS;
  localparam int unsigned STEPS_PER_STAGE = 8;
  localparam int unsigned DD_STAGES = BIN_W / STEPS_PER_STAGE;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // bcd accumulator and the binary bits still to shift in
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
  } dd_t;

  // one shift-and-add-3 step
  function automatic dd_t dd_step(input dd_t x);
    dd_t r;
    r = x;
    for (int d = 0; d < DIGITS; d++) begin
      if (r.bcd[4*d +: 4] >= 4'd5) begin
        r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
      end
    end
    r = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
    return r;
  endfunction

endpackage

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// signed 32-bit integer to decimal ascii text, pipelined converter with character serializer
//
//  channel | ports                              | word
//  --------+------------------------------------+--------------------------------
//  input   | value_valid, value_ready, value    | one signed 32-bit integer
//  output  | char_valid, char_ready, char_code, | one ascii character, last marks
//          | last                               | the final character of a value
//
// A word passes an input register and four double-dabble stages of eight steps
// each, and is then loaded into the serializer, which puts out its first character.
// The serializer sends one character per cycle while char_ready is high: a value
// gives 1 to 11 characters (sign plus up to ten digits), which sets the sustained rate.
// The stages take a new word every cycle while the serializer keeps pace;
// a stall on the output backs up through the stages without loss.
// Synchronous reset empties all stages and the serializer.
module signed_int_to_decimal_ascii_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               value_valid,
  output logic               value_ready,
  input  logic signed [31:0] value,
  output logic               char_valid,
  input  logic               char_ready,
  output logic [7:0]         char_code,
  output logic               last
);

  localparam int unsigned NST = sitda_pkg::DD_STAGES + 1;

  sitda_pkg::dd_t st_dd  [NST];
  logic           st_neg [NST];
  logic           st_vld [NST];
  logic           st_rdy [NST+1];
  sitda_pkg::dd_t dd_next [NST];

  logic       ser_busy;
  logic       ser_neg;
  logic [3:0] ser_dig [sitda_pkg::DIGITS];
  logic [3:0] idx;
  logic [3:0] idx_next;
  logic       ld_rdy;
  logic       ld;
  logic       fin;
  logic [3:0] cur_dig;

  // magnitude of the incoming word, then eight double-dabble steps per stage
  always_comb begin
    sitda_pkg::dd_t tmp;
    dd_next[0].bcd = '0;
    dd_next[0].bin = value[31] ? 32'(~value + 32'sd1) : 32'(value);
    for (int k = 1; k < NST; k++) begin
      tmp = st_dd[k-1];
      for (int j = 0; j < sitda_pkg::STEPS_PER_STAGE; j++) begin
        tmp = sitda_pkg::dd_step(tmp);
      end
      dd_next[k] = tmp;
    end
  end

  // backpressure chain through the stages
  always_comb begin
    st_rdy[NST] = ld_rdy;
    for (int k = NST - 1; k >= 0; k--) begin
      st_rdy[k] = !st_vld[k] || st_rdy[k+1];
    end
  end

  assign value_ready = st_rdy[0];

  // stage registers
  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic in_vld;
    logic in_neg;
    if (k == 0) begin : g_first
      assign in_vld = value_valid;
      assign in_neg = value[31];
    end else begin : g_rest
      assign in_vld = st_vld[k-1];
      assign in_neg = st_neg[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[k] <= 1'b0;
      end else if (st_rdy[k]) begin
        st_vld[k] <= in_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (st_rdy[k] && in_vld) begin
        st_dd[k]  <= dd_next[k];
        st_neg[k] <= in_neg;
      end
    end
  end

  // current character and end of run
  assign cur_dig    = ser_dig[idx];
  assign char_valid = ser_busy;
  assign char_code  = ser_neg ? sitda_pkg::CHAR_MINUS : (sitda_pkg::CHAR_ZERO | {4'd0, cur_dig});
  assign last       = !ser_neg && (idx == 4'd0);
  assign fin        = char_valid && char_ready && last;
  assign ld_rdy     = !ser_busy || fin;
  assign ld         = st_vld[NST-1] && ld_rdy;

  // leading digit position of the finished value
  always_comb begin
    idx_next = 4'd0;
    for (int j = 0; j < sitda_pkg::DIGITS; j++) begin
      if (st_dd[NST-1].bcd[4*j +: 4] != 4'd0) begin
        idx_next = 4'(j);
      end
    end
  end

  // serializer control
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_busy <= 1'b0;
      ser_neg  <= 1'b0;
      idx      <= 4'd0;
    end else if (ld) begin
      ser_busy <= 1'b1;
      ser_neg  <= st_neg[NST-1];
      idx      <= idx_next;
    end else if (char_valid && char_ready) begin
      if (ser_neg) begin
        ser_neg <= 1'b0;
      end else if (idx == 4'd0) begin
        ser_busy <= 1'b0;
      end else begin
        idx <= idx - 4'd1;
      end
    end
  end

  // serializer digits
  always_ff @(posedge clk) begin
    if (ld) begin
      for (int j = 0; j < sitda_pkg::DIGITS; j++) begin
        ser_dig[j] <= st_dd[NST-1].bcd[4*j +: 4];
      end
    end
  end

  // checks
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (char_code == sitda_pkg::CHAR_MINUS) ||
                   (char_code >= sitda_pkg::CHAR_ZERO && char_code <= sitda_pkg::CHAR_NINE))
    else $error("character code out of range");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_code == sitda_pkg::CHAR_MINUS) |-> !last)
    else $error("minus sign flagged as last");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !value_ready |-> (st_vld[0] && !char_ready) || (st_vld[0] && char_valid))
    else $error("input stalled with empty first stage");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !char_valid)
    else $error("output valid right after reset");

endmodule
